// ===== design/dfl_pkg.sv =====
// Shared types and constants for the dual frequency limit monitor.
`timescale 1ns / 1ps

package dfl_pkg;

    localparam int DIV_W = 20;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_W-1:0] DIVIDEND = 20'd1000000;
    localparam logic [DIV_W-1:0] ZERO_CAP_QUOT = 20'd32767;

    localparam logic [7:0] REG_JUMP_THR = 8'd0;
    localparam logic [7:0] REG_LIMIT = 8'd1;
    localparam logic [7:0] REG_OFFSET = 8'd2;

    localparam logic [9:0] JUMP_THR_RST = 10'd1000;
    localparam logic [13:0] LIMIT_RST = 14'd5000;
    localparam logic signed [10:0] OFFSET_RST = 11'sd0;

    localparam logic [7:0] CNT_MAX = 8'hFF;
    localparam logic [7:0] ALARM_LEVEL = 8'd3;
    localparam logic [15:0] WIN_MIN_RST = 16'hFFFF;

    typedef struct packed {
        logic        cmd;
        logic [15:0] capture_a;
        logic [15:0] capture_b;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] freq_a;
        logic signed [15:0] freq_b;
        logic signed [15:0] period_a;
        logic signed [15:0] period_b;
        logic               over_a;
        logic               over_b;
        logic [7:0]         over_count_a;
        logic [7:0]         over_count_b;
        logic [7:0]         jump_count_a;
        logic [7:0]         jump_count_b;
        logic               jump_alarm;
    } t_out_item;

    typedef struct packed {
        logic [9:0]         jump_threshold;
        logic [13:0]        limit_hz;
        logic signed [10:0] offset_hz;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] freq;
        logic signed [15:0] period;
        logic               over;
        logic [7:0]         over_count;
        logic [7:0]         jump_count;
    } t_lane_res;

endpackage

// ===== design/dfl_div.sv =====
// Iterative restoring divider: constant dividend over a 16-bit divisor, one bit per cycle.
`timescale 1ns / 1ps

module dfl_div
    import dfl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [15:0]      i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0]          r_rem, n_rem;
    logic [DIV_W-1:0]     r_dvd, n_dvd;
    logic [DIV_W-1:0]     r_quot, n_quot;
    logic [15:0]          r_dsr, n_dsr;
    logic [16:0]          w_trial;
    logic                 w_ge;

    assign w_trial = {r_rem, r_dvd[DIV_W-1]};
    assign w_ge = w_trial >= {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_dvd = r_dvd;
        n_quot = r_quot;
        n_dsr = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt = DIV_CNT_W'(DIV_W - 1);
            n_rem = '0;
            n_dvd = DIVIDEND;
            n_quot = '0;
            n_dsr = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? 16'(w_trial - {1'b0, r_dsr}) : w_trial[15:0];
            n_quot = {r_quot[DIV_W-2:0], w_ge};
            n_dvd = {r_dvd[DIV_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_quot <= n_quot;
        r_dsr <= n_dsr;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== design/dfl_lane.sv =====
// One channel lane: frequency and period division, limit crossing and window spread tracking.
`timescale 1ns / 1ps

module dfl_lane
    import dfl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_clr,
    input  logic        i_win_end,
    input  logic [15:0] i_capture,
    input  t_cfg        i_cfg,
    output logic        o_done,
    output t_lane_res   o_res
);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_FREQ = 2'd1;
    localparam logic [1:0] L_PER = 2'd2;

    logic [1:0]         r_state, n_state;
    logic               r_done, n_done;
    logic               r_cap_zero, n_cap_zero;
    logic               r_win_end, n_win_end;
    logic signed [15:0] r_freq, n_freq;
    logic signed [15:0] r_period, n_period;
    logic               r_above, n_above;
    logic [7:0]         r_over_cnt, n_over_cnt;
    logic [7:0]         r_jump_cnt, n_jump_cnt;
    logic [15:0]        r_max, n_max;
    logic [15:0]        r_min, n_min;

    logic               w_div_start;
    logic [15:0]        w_divisor;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_quot;
    logic [DIV_W-1:0]   w_q;
    logic signed [21:0] w_sum;
    logic signed [15:0] w_freq;
    logic [15:0]        w_v;
    logic [15:0]        w_max;
    logic [15:0]        w_min;
    logic               w_over;
    logic               w_jump;

    dfl_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_divisor (w_divisor),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    assign w_q = r_cap_zero ? ZERO_CAP_QUOT : w_quot;
    assign w_sum = $signed({2'b00, w_q}) + 22'(i_cfg.offset_hz);

    always_comb begin
        if (w_sum > 22'sd32767) begin
            w_freq = 16'sh7FFF;
        end else if (w_sum < -22'sd32768) begin
            w_freq = 16'sh8000;
        end else begin
            w_freq = w_sum[15:0];
        end
    end

    assign w_div_start = (r_state == L_IDLE && i_start && !i_clr)
                       || (r_state == L_FREQ && w_div_done);
    assign w_divisor = (r_state == L_IDLE) ? i_capture : w_freq;

    assign w_v = r_freq[15] ? 16'd0 : r_freq;
    assign w_max = (w_v >= r_max) ? w_v : r_max;
    assign w_min = (w_v <= r_min) ? w_v : r_min;
    assign w_over = r_freq > $signed({2'b00, i_cfg.limit_hz});
    assign w_jump = (w_max >= w_min) && ((w_max - w_min) > {6'd0, i_cfg.jump_threshold});

    always_comb begin
        n_state = r_state;
        n_done = 1'b0;
        n_cap_zero = r_cap_zero;
        n_win_end = r_win_end;
        n_freq = r_freq;
        n_period = r_period;
        n_above = r_above;
        n_over_cnt = r_over_cnt;
        n_jump_cnt = r_jump_cnt;
        n_max = r_max;
        n_min = r_min;
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    if (i_clr) begin
                        n_freq = '0;
                        n_period = '0;
                        n_over_cnt = '0;
                        n_jump_cnt = '0;
                        n_done = 1'b1;
                    end else begin
                        n_cap_zero = (i_capture == '0);
                        n_win_end = i_win_end;
                        n_state = L_FREQ;
                    end
                end
            end
            L_FREQ: begin
                if (w_div_done) begin
                    n_freq = w_freq;
                    n_state = L_PER;
                end
            end
            L_PER: begin
                if (w_div_done) begin
                    if (r_freq <= 16'sd0) begin
                        n_period = -16'sd1;
                    end else if (w_quot > 20'd32767) begin
                        n_period = 16'sh7FFF;
                    end else begin
                        n_period = w_quot[15:0];
                    end
                    n_above = w_over;
                    if (w_over && !r_above && r_over_cnt != CNT_MAX) begin
                        n_over_cnt = r_over_cnt + 1'b1;
                    end
                    if (r_win_end) begin
                        if (w_jump && r_jump_cnt != CNT_MAX) begin
                            n_jump_cnt = r_jump_cnt + 1'b1;
                        end
                        n_max = '0;
                        n_min = WIN_MIN_RST;
                    end else begin
                        n_max = w_max;
                        n_min = w_min;
                    end
                    n_done = 1'b1;
                    n_state = L_IDLE;
                end
            end
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done <= 1'b0;
            r_above <= 1'b0;
            r_over_cnt <= '0;
            r_jump_cnt <= '0;
            r_max <= '0;
            r_min <= WIN_MIN_RST;
        end else begin
            r_state <= n_state;
            r_done <= n_done;
            r_above <= n_above;
            r_over_cnt <= n_over_cnt;
            r_jump_cnt <= n_jump_cnt;
            r_max <= n_max;
            r_min <= n_min;
        end
        r_cap_zero <= n_cap_zero;
        r_win_end <= n_win_end;
        r_freq <= n_freq;
        r_period <= n_period;
    end

    assign o_done = r_done;
    assign o_res.freq = r_freq;
    assign o_res.period = r_period;
    assign o_res.over = r_above;
    assign o_res.over_count = r_over_cnt;
    assign o_res.jump_count = r_jump_cnt;

endmodule

// ===== design/dfl_merge.sv =====
// Merge stage: combines both lane results into the output register.
`timescale 1ns / 1ps

module dfl_merge
    import dfl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_lane_res i_res_a,
    input  t_lane_res i_res_b,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out
);

    logic      r_valid, n_valid;
    t_out_item r_out, n_out;

    always_comb begin
        n_valid = r_valid;
        n_out = r_out;
        if (r_valid && i_out_ready) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid = 1'b1;
            n_out.freq_a = i_res_a.freq;
            n_out.freq_b = i_res_b.freq;
            n_out.period_a = i_res_a.period;
            n_out.period_b = i_res_b.period;
            n_out.over_a = i_res_a.over;
            n_out.over_b = i_res_b.over;
            n_out.over_count_a = i_res_a.over_count;
            n_out.over_count_b = i_res_b.over_count;
            n_out.jump_count_a = i_res_a.jump_count;
            n_out.jump_count_b = i_res_b.jump_count;
            n_out.jump_alarm = (i_res_a.jump_count >= ALARM_LEVEL)
                            || (i_res_b.jump_count >= ALARM_LEVEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_valid;
    assign o_out = r_out;

endmodule

// ===== design/dual_freq_limit_monitor.sv =====
// Top level of the dual frequency limit monitor: config registers, window position, sequencing.
//
// Channel  Direction  Handshake                      Payload
// in       input      i_in_valid / o_in_ready        i_in  (t_in_item)
// out      output     o_out_valid / i_out_ready      o_out (t_out_item)
// cfg      input      i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// A measure transaction runs two divisions in series (frequency, then period)
// in each lane's bit-serial divider; both lanes run in parallel.
// Reset is synchronous, active low; config is always ready.
// The next input is taken while a finished result waits in the output register;
// a lane result that finds the output register full waits in the lane.
`timescale 1ns / 1ps

module dual_freq_limit_monitor
    import dfl_pkg::*;
#(
    parameter int WINDOW = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [4:0] WIN_LEN = 5'(WINDOW);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_RUN = 2'd1;

    logic [1:0] r_state, n_state;
    t_cfg       r_cfg, n_cfg;
    logic [4:0] r_win_pos, n_win_pos;
    logic       r_done_a, n_done_a;
    logic       r_done_b, n_done_b;

    logic       w_accept;
    logic       w_clr;
    logic [4:0] w_pos_inc;
    logic       w_win_end;
    logic       w_done_a;
    logic       w_done_b;
    logic       w_both;
    logic       w_load;
    t_lane_res  w_res_a;
    t_lane_res  w_res_b;

    assign o_in_ready = (r_state == T_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept = i_in_valid && o_in_ready;
    assign w_clr = i_in.cmd;
    assign w_pos_inc = r_win_pos + 1'b1;
    assign w_win_end = (w_pos_inc == '0) || (w_pos_inc >= WIN_LEN);

    dfl_lane u_lane_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_clr     (w_clr),
        .i_win_end (w_win_end),
        .i_capture (i_in.capture_a),
        .i_cfg     (r_cfg),
        .o_done    (w_done_a),
        .o_res     (w_res_a)
    );

    dfl_lane u_lane_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_clr     (w_clr),
        .i_win_end (w_win_end),
        .i_capture (i_in.capture_b),
        .i_cfg     (r_cfg),
        .o_done    (w_done_b),
        .o_res     (w_res_b)
    );

    assign w_both = (r_done_a || w_done_a) && (r_done_b || w_done_b);
    assign w_load = (r_state == T_RUN) && w_both && (!o_out_valid || i_out_ready);

    dfl_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_res_a     (w_res_a),
        .i_res_b     (w_res_b),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_JUMP_THR: n_cfg.jump_threshold = i_cfg_data[9:0];
                REG_LIMIT:    n_cfg.limit_hz = i_cfg_data[13:0];
                REG_OFFSET:   n_cfg.offset_hz = i_cfg_data[10:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_win_pos = r_win_pos;
        n_done_a = r_done_a;
        n_done_b = r_done_b;
        case (r_state)
            T_IDLE: begin
                if (w_accept) begin
                    n_state = T_RUN;
                    n_done_a = 1'b0;
                    n_done_b = 1'b0;
                    if (!w_clr) begin
                        n_win_pos = w_win_end ? 5'd0 : w_pos_inc;
                    end
                end
            end
            T_RUN: begin
                n_done_a = r_done_a || w_done_a;
                n_done_b = r_done_b || w_done_b;
                if (w_load) begin
                    n_state = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_win_pos <= '0;
            r_done_a <= 1'b0;
            r_done_b <= 1'b0;
            r_cfg.jump_threshold <= JUMP_THR_RST;
            r_cfg.limit_hz <= LIMIT_RST;
            r_cfg.offset_hz <= OFFSET_RST;
        end else begin
            r_state <= n_state;
            r_win_pos <= n_win_pos;
            r_done_a <= n_done_a;
            r_done_b <= n_done_b;
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== design/dfl_checker.sv =====
// Port-level assertions for the dual frequency limit monitor, bound to the top level.
`timescale 1ns / 1ps

module dfl_checker
    import dfl_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output transaction changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a transaction is in flight");

    a_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.jump_alarm ==
            ((o_out.jump_count_a >= ALARM_LEVEL) || (o_out.jump_count_b >= ALARM_LEVEL)))
        else $error("jump alarm disagrees with jump counts");

    a_neg_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.freq_a[15] |-> o_out.period_a == -16'sd1)
        else $error("negative frequency without invalid period");

endmodule

bind dual_freq_limit_monitor dfl_checker u_dfl_checker (.*);

// ===== verif/tb_dual_freq_limit_monitor.sv =====
// Self-checking testbench for the dual frequency limit monitor: random traffic against a local predictor.
`timescale 1ns / 1ps

module tb_dual_freq_limit_monitor;
    import dfl_pkg::*;

    localparam int WIN = 30;
    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;
    localparam logic [7:0] REG_UNMAPPED = 8'd7;
    localparam int SATURATE_ITEMS = 520;
    localparam int RUN_ITEMS = 28;
    localparam int MAX_PRINTS = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    dual_freq_limit_monitor #(
        .WINDOW(WIN)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out(o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    t_in_item  measure_queue[$];
    t_out_item pending_readings[$];
    int        issued_cnt = 0;
    int        accepted_cnt = 0;
    int        err_count = 0;
    bit        in_fire = 1'b0;
    int        send_gap = 0;
    int        send_calm = 0;
    int        stall_left = 0;
    int        recv_calm = 0;

    // shadow of the block's registers and state
    logic [9:0]  cur_jump_thr;
    logic [13:0] cur_limit;
    int          cur_offset;
    logic        lane_above[2];
    int          win_hi[2];
    int          win_lo[2];
    logic [4:0]  win_fill;
    int          over_tally[2];
    int          jump_tally[2];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int calibrated_freq(logic [15:0] cap, int ofs);
        int q;
        int f;
        q = (cap == 16'd0) ? 32767 : 1000000 / int'(cap);
        f = q + ofs;
        if (f > 32767) f = 32767;
        if (f < -32768) f = -32768;
        return f;
    endfunction

    function automatic int period_of(int f);
        int p;
        if (f <= 0) return -1;
        p = 1000000 / f;
        return (p > 32767) ? 32767 : p;
    endfunction

    task automatic reset_shadow();
        cur_jump_thr = JUMP_THR_RST;
        cur_limit = LIMIT_RST;
        cur_offset = 0;
        win_fill = '0;
        for (int ch = 0; ch < 2; ch++) begin
            lane_above[ch] = 1'b0;
            win_hi[ch] = 0;
            win_lo[ch] = 65535;
            over_tally[ch] = 0;
            jump_tally[ch] = 0;
        end
    endtask

    task automatic shadow_write(logic [7:0] idx, logic [15:0] d);
        if (idx == REG_JUMP_THR) cur_jump_thr = d[9:0];
        else if (idx == REG_LIMIT) cur_limit = d[13:0];
        else if (idx == REG_OFFSET) cur_offset = {{21{d[10]}}, d[10:0]};
    endtask

    task automatic apply_reading(input t_in_item it, output t_out_item res);
        int         f[2];
        int         p[2];
        logic [15:0] caps[2];
        logic       ov;
        int         v;
        res = '0;
        f[0] = 0;
        f[1] = 0;
        p[0] = 0;
        p[1] = 0;
        if (it.cmd == CMD_CLEAR) begin
            for (int ch = 0; ch < 2; ch++) begin
                over_tally[ch] = 0;
                jump_tally[ch] = 0;
            end
        end else begin
            caps[0] = it.capture_a;
            caps[1] = it.capture_b;
            for (int ch = 0; ch < 2; ch++) begin
                f[ch] = calibrated_freq(caps[ch], cur_offset);
                p[ch] = period_of(f[ch]);
                ov = (f[ch] > int'(cur_limit));
                if (ov && !lane_above[ch] && over_tally[ch] < 255) over_tally[ch]++;
                lane_above[ch] = ov;
                v = (f[ch] < 0) ? 0 : f[ch];
                if (v >= win_hi[ch]) win_hi[ch] = v;
                if (v <= win_lo[ch]) win_lo[ch] = v;
            end
            win_fill = win_fill + 5'd1;
            if (win_fill == 5'd0 || win_fill >= WIN) begin
                for (int ch = 0; ch < 2; ch++) begin
                    if (win_hi[ch] >= win_lo[ch] && win_hi[ch] - win_lo[ch] > int'(cur_jump_thr)
                        && jump_tally[ch] < 255)
                        jump_tally[ch]++;
                    win_hi[ch] = 0;
                    win_lo[ch] = 65535;
                end
                win_fill = '0;
            end
        end
        res.freq_a = 16'(f[0]);
        res.freq_b = 16'(f[1]);
        res.period_a = 16'(p[0]);
        res.period_b = 16'(p[1]);
        res.over_a = lane_above[0];
        res.over_b = lane_above[1];
        res.over_count_a = 8'(over_tally[0]);
        res.over_count_b = 8'(over_tally[1]);
        res.jump_count_a = 8'(jump_tally[0]);
        res.jump_count_b = 8'(jump_tally[1]);
        res.jump_alarm = (jump_tally[0] >= 3) || (jump_tally[1] >= 3);
    endtask

    task automatic report_mismatch(string msg);
        if (err_count < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h (reading %0d)",
                                      name, got, want, accepted_cnt));
    endtask

    task automatic compare_reading(t_out_item got, t_out_item want);
        check_field("freq_a", got.freq_a, want.freq_a);
        check_field("freq_b", got.freq_b, want.freq_b);
        check_field("period_a", got.period_a, want.period_a);
        check_field("period_b", got.period_b, want.period_b);
        check_field("over_a", got.over_a, want.over_a);
        check_field("over_b", got.over_b, want.over_b);
        check_field("over_count_a", got.over_count_a, want.over_count_a);
        check_field("over_count_b", got.over_count_b, want.over_count_b);
        check_field("jump_count_a", got.jump_count_a, want.jump_count_a);
        check_field("jump_count_b", got.jump_count_b, want.jump_count_b);
        check_field("jump_alarm", got.jump_alarm, want.jump_alarm);
    endtask

    // idle lengths: mostly short, a few long, with quiet stretches of none
    task automatic pick_idle(inout int calm, output int len);
        int r;
        r = $urandom_range(0, 999);
        len = 0;
        if (calm > 0) calm--;
        else if (r < 15) calm = $urandom_range(20, 80);
        else if (r < 500) len = 0;
        else if (r < 850) len = $urandom_range(1, 3);
        else if (r < 970) len = $urandom_range(4, 15);
        else len = $urandom_range(30, 120);
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        in_fire = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_readings.size() == 0)
                    report_mismatch("result transaction with nothing expected");
                else
                    compare_reading(o_out, pending_readings.pop_front());
            end
            if (i_cfg_valid && o_cfg_ready) shadow_write(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                in_fire = 1'b1;
                apply_reading(i_in, want);
                pending_readings.push_back(want);
                accepted_cnt++;
            end
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (in_fire || !i_in_valid) begin
            if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap--;
            end else if (measure_queue.size() > 0) begin
                i_in <= measure_queue.pop_front();
                i_in_valid <= 1'b1;
                pick_idle(send_calm, send_gap);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 9) < 2) pick_idle(recv_calm, stall_left);
        end
    end

    task automatic send(logic cmd, logic [15:0] cap_a, logic [15:0] cap_b);
        t_in_item it;
        it.cmd = cmd;
        it.capture_a = cap_a;
        it.capture_b = cap_b;
        measure_queue.push_back(it);
        issued_cnt++;
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (accepted_cnt != issued_cnt || pending_readings.size() != 0);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(int thr, int lim, int ofs);
        write_reg(REG_JUMP_THR, 16'(thr));
        write_reg(REG_LIMIT, 16'(lim));
        write_reg(REG_OFFSET, 16'(ofs));
    endtask

    function automatic logic [15:0] random_capture(int center);
        int r;
        int target;
        int q;
        r = $urandom_range(0, 99);
        if (r < 20) return 16'($urandom_range(0, 65535));
        if (r < 35) return 16'($urandom_range(0, 40));
        if (r < 65) begin
            target = int'(cur_limit) + $urandom_range(0, 400) - 200;
            q = target - cur_offset;
            if (q <= 15) return 16'd65535;
            return 16'(1000000 / q);
        end
        if (r < 85) return 16'(center + $urandom_range(0, 120) - 60);
        return 16'($urandom_range(1000, 65535));
    endfunction

    task automatic random_run(int n);
        int center;
        center = 500;
        for (int k = 0; k < n; k++) begin
            if (k % WIN == 0) center = $urandom_range(100, 2000);
            if ($urandom_range(0, 99) < 4)
                send(CMD_CLEAR, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            else
                send(CMD_MEASURE, random_capture(center), random_capture(center));
            if (k == n / 2) settle();
        end
        settle();
    endtask

    initial begin
        reset_shadow();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: clamps, limit edges, clear
        send(CMD_MEASURE, 16'd0, 16'd0);
        send(CMD_MEASURE, 16'd1, 16'd65535);
        send(CMD_MEASURE, 16'd30, 16'd31);
        send(CMD_MEASURE, 16'd200, 16'd199);
        send(CMD_MEASURE, 16'd199, 16'd200);
        send(CMD_MEASURE, 16'd201, 16'd1000);
        send(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
        send(CMD_MEASURE, 16'd2, 16'd3);
        send(CMD_MEASURE, 16'd100, 16'd65535);
        send(CMD_MEASURE, 16'hAAAA, 16'h5555);
        settle();

        // low extremes: negative and zero frequency, period clamp
        write_all(100, 1000, -1000);
        send(CMD_MEASURE, 16'd65535, 16'd1000);
        send(CMD_MEASURE, 16'd1, 16'd0);
        send(CMD_MEASURE, 16'd999, 16'd1001);
        send(CMD_MEASURE, 16'd500, 16'd990);
        send(CMD_CLEAR, 16'h0000, 16'h0000);
        send(CMD_MEASURE, 16'd1000, 16'd65535);
        settle();

        // high extremes
        write_all(1000, 10000, 1000);
        send(CMD_MEASURE, 16'd0, 16'd1);
        send(CMD_MEASURE, 16'd111, 16'd100);
        send(CMD_MEASURE, 16'd2000, 16'd65535);
        settle();

        random_run(RUN_ITEMS);

        write_all($urandom_range(100, 1000), $urandom_range(1000, 10000),
                  $urandom_range(0, 2000) - 1000);
        random_run(RUN_ITEMS);

        // only the low bits of a register are kept; unmapped index changes nothing
        write_reg(REG_JUMP_THR, 16'($urandom_range(0, 65535)));
        write_reg(REG_LIMIT, 16'($urandom_range(0, 65535)));
        write_reg(REG_OFFSET, 16'($urandom_range(0, 65535)));
        write_reg(REG_UNMAPPED, 16'hFFFF);
        random_run(RUN_ITEMS);

        write_all(100, 1000, -1000);
        random_run(RUN_ITEMS);

        // alternate far above and far below the limit until the crossing counters saturate
        write_all(JUMP_THR_RST, LIMIT_RST, 0);
        for (int k = 0; k < SATURATE_ITEMS; k++) begin
            if (k % 2 == 0) send(CMD_MEASURE, 16'd100, 16'd65535);
            else send(CMD_MEASURE, 16'd65535, 16'd100);
        end
        send(CMD_CLEAR, 16'd0, 16'd0);
        send(CMD_MEASURE, 16'd100, 16'd100);
        settle();

        repeat (60) @(posedge i_clk);
        if (err_count == 0) begin
            $display("dual_freq_limit_monitor verification clean");
        end else begin
            $display("dual_freq_limit_monitor verification failed");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("dual_freq_limit_monitor verification failed");
        $finish;
    end

endmodule
